### rtl/sobel_edge_magnitude_top_defines.svh
// Assertion macros shared by the Sobel edge magnitude RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SEM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sem_pkg.sv
// Shared types and constants of the Sobel edge magnitude block.
package sem_pkg;

   // Register map: byte address 4*index
   localparam int          CSR_AW     = 4;
   localparam logic [1:0]  REG_WIDTH  = 2'd0;
   localparam logic [1:0]  REG_HEIGHT = 2'd1;
   localparam logic [1:0]  REG_EUCLID = 2'd2;

   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [15:0] HEIGHT_RESET = 16'd480;
   localparam logic [10:0] WIDTH_MIN    = 11'd3;
   localparam logic [15:0] HEIGHT_MIN   = 16'd3;
   localparam logic [7:0]  MAG_MAX      = 8'd255;

   // One entry of the line store: the two rows above a column
   typedef struct packed {
      logic [7:0] two_above;
      logic [7:0] above;
   } line_word_type;

   // Bookkeeping that travels with an item down the pipeline
   typedef struct packed {
      logic        emit;
      logic        zero;
      logic [15:0] row;
      logic [9:0]  col;
      logic        done;
   } meta_type;

endpackage

### rtl/sobel_edge_magnitude_top.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream: top level.
// The block takes one pixel per clock while the output is not stalled, and its
// results leave through the output register; a stalled result halts the
// whole pipeline, and pixels are taken again as soon as it leaves. The rate of
// one pixel per cycle is set by the line store, which is read at the new
// pixel's column and written back from stage 1 when the pipeline advances;
// a write and a read of one column in the same cycle are bridged by forwarding.
// Pixels at row 0 or column 0 produce no result; the last row and column of a
// frame are never produced. The line store needs no clearing after reset; its
// contents are only meaningful once a full row has passed at the current width.
`include "sobel_edge_magnitude_top_defines.svh"

module sobel_edge_magnitude_top import sem_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // Pixel input
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_pixel,
   input  logic              req_frame_start,
   // Result output
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_magnitude,
   output logic [15:0]       rsp_out_row,
   output logic [9:0]        rsp_out_col,
   output logic              rsp_frame_done,
   // Register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int WCAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

   logic [10:0]   width_ff;
   logic [15:0]   height_ff;
   logic          euclid_ff;
   logic          csr_wr;

   logic [10:0]   w_eff;
   logic [15:0]   h_eff;
   logic          adv;
   logic          accept;

   logic [10:0]   col_ff;
   logic [15:0]   row_ff;
   logic [10:0]   col_in;
   logic [15:0]   row_in;
   logic [10:0]   col_start;
   logic [15:0]   row_start;
   logic          wrap_col;
   logic [15:0]   row_wrap;
   logic [10:0]   cur_col;
   logic [15:0]   cur_row;
   logic [10:0]   nxt_col;
   logic [15:0]   nxt_row;
   meta_type      cur_meta;

   logic          s1_valid_ff;
   logic [7:0]    s1_pixel_ff;
   logic [AW-1:0] s1_addr_ff;
   meta_type      s1_meta_ff;
   meta_type      s1_meta_gated;
   logic          s1_wr;
   logic [AW-1:0] rd_addr;

   logic          fwd_ff;
   line_word_type fwd_data_ff;
   line_word_type mem_rd_data;
   line_word_type word;
   line_word_type wr_data;

   logic [9:0]    ax;
   logic [9:0]    ay;
   meta_type      grad_meta;
   logic [7:0]    mag;
   meta_type      mag_meta;

   logic          rsp_valid_ff;
   logic [7:0]    rsp_mag_ff;
   logic [15:0]   rsp_row_ff;
   logic [9:0]    rsp_col_ff;
   logic          rsp_done_ff;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         euclid_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_WIDTH:  width_ff  <= csr_pwdata[10:0];
            REG_HEIGHT: height_ff <= csr_pwdata[15:0];
            REG_EUCLID: euclid_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = {21'd0, width_ff};
         REG_HEIGHT: csr_prdata = {16'd0, height_ff};
         REG_EUCLID: csr_prdata = {31'd0, euclid_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // Saturate the image size
   always_comb begin
      if (width_ff < WIDTH_MIN) begin
         w_eff = WIDTH_MIN;
      end else if (32'(width_ff) > WCAP) begin
         w_eff = 11'(WCAP);
      end else begin
         w_eff = width_ff;
      end
      h_eff = (height_ff < HEIGHT_MIN) ? HEIGHT_MIN : height_ff;
   end

   // Pipeline moves whenever the output register can take a result
   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid & req_ready;

   // Position of the incoming pixel and of the one after it
   always_comb begin
      col_start = req_frame_start ? '0 : col_ff;
      row_start = req_frame_start ? '0 : row_ff;
      wrap_col  = col_start >= w_eff;
      row_wrap  = wrap_col ? row_start + 16'd1 : row_start;
      cur_col   = wrap_col ? '0 : col_start;
      cur_row   = (row_wrap >= h_eff) ? '0 : row_wrap;
      nxt_col   = cur_col + 11'd1;
      nxt_row   = cur_row + 16'd1;
      if (nxt_col >= w_eff) begin
         col_in = '0;
         row_in = (nxt_row >= h_eff) ? '0 : nxt_row;
      end else begin
         col_in = nxt_col;
         row_in = cur_row;
      end
      cur_meta.emit = (cur_row != '0) && (cur_col != '0);
      cur_meta.zero = (cur_row < 16'd2) || (cur_col < 11'd2);
      cur_meta.row  = cur_row - 16'd1;
      cur_meta.col  = 10'(cur_col - 11'd1);
      cur_meta.done = (cur_row == h_eff - 16'd1) && (cur_col == w_eff - 11'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1: line store read in flight
   assign rd_addr = AW'(cur_col);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_addr_ff  <= rd_addr;
         s1_meta_ff  <= cur_meta;
      end
   end

   // Read-modify-write of the column entry; forward a write the read missed
   assign s1_wr             = adv & s1_valid_ff;
   assign word              = fwd_ff ? fwd_data_ff : mem_rd_data;
   assign wr_data.two_above = word.above;
   assign wr_data.above     = s1_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (adv) begin
         fwd_ff <= accept & s1_wr & (rd_addr == s1_addr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= wr_data;
      end
   end

   sem_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (s1_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data)
   );

   // Drop the result flag of an empty stage
   always_comb begin
      s1_meta_gated      = s1_meta_ff;
      s1_meta_gated.emit = s1_meta_ff.emit & s1_valid_ff;
   end

   sem_window u_window (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .shift_en (s1_wr),
      .col_top  (word.two_above),
      .col_mid  (word.above),
      .col_bot  (s1_pixel_ff),
      .meta_in  (s1_meta_gated),
      .ax       (ax),
      .ay       (ay),
      .meta_out (grad_meta)
   );

   sem_magnitude u_magnitude (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .use_euclid (euclid_ff),
      .ax         (ax),
      .ay         (ay),
      .meta_in    (grad_meta),
      .mag        (mag),
      .meta_out   (mag_meta)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mag_meta.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_mag_ff  <= mag;
         rsp_row_ff  <= mag_meta.row;
         rsp_col_ff  <= mag_meta.col;
         rsp_done_ff <= mag_meta.done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = rsp_mag_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_frame_done = rsp_done_ff;

   // Checks
   `SEM_ASSERT_NOW(a_fwd_needs_item, fwd_ff, s1_valid_ff, "forward set without an item in stage 1")
   `SEM_ASSERT_NOW(a_no_take_on_stall, rsp_valid && !rsp_ready, !req_ready, "item taken while output stalled")
   `SEM_ASSERT_NEXT(a_take_fills_s1, req_valid && req_ready, s1_valid_ff, "taken item missing in stage 1")
   `SEM_ASSERT_NEXT(a_stall_holds_s1, s1_valid_ff && !adv, s1_valid_ff && $stable(s1_addr_ff), "stage 1 lost its item during a stall")

endmodule

### rtl/sem_line_store.sv
// Line store: two previous image rows, one read and one write port, registered read.
module sem_line_store import sem_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output line_word_type rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  line_word_type wr_data
);

   line_word_type line_mem [DEPTH];
   line_word_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered and valid in the cycle after an enabled read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sem_window.sv
// 3x3 pixel window and the absolute Sobel gradients taken from it.
module sem_window import sem_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       shift_en,
   input  logic [7:0] col_top,
   input  logic [7:0] col_mid,
   input  logic [7:0] col_bot,
   input  meta_type   meta_in,
   output logic [9:0] ax,
   output logic [9:0] ay,
   output meta_type   meta_out
);

   logic [7:0] win_ff [9];
   meta_type   meta2_ff;
   meta_type   meta3_ff;
   logic [9:0] ax_ff;
   logic [9:0] ay_ff;
   logic [9:0] px;
   logic [9:0] nx;
   logic [9:0] py;
   logic [9:0] ny;

   // Shift the window left and insert the new right column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= col_top;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= col_mid;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= col_bot;
      end
   end

   // Kernel sums: right minus left column, bottom minus top row
   always_comb begin
      px = {2'b00, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b00, win_ff[8]};
      nx = {2'b00, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b00, win_ff[6]};
      py = {2'b00, win_ff[6]} + {1'b0, win_ff[7], 1'b0} + {2'b00, win_ff[8]};
      ny = {2'b00, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b00, win_ff[2]};
   end

   // Advance item tags
   always_ff @(posedge clock) begin
      if (reset) begin
         meta2_ff <= '0;
         meta3_ff <= '0;
      end else if (adv) begin
         meta2_ff <= meta_in;
         meta3_ff <= meta2_ff;
      end
   end

   // Register absolute differences
   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff <= (px >= nx) ? px - nx : nx - px;
         ay_ff <= (py >= ny) ? py - ny : ny - py;
      end
   end

   assign ax       = ax_ff;
   assign ay       = ay_ff;
   assign meta_out = meta3_ff;

endmodule

### rtl/sem_magnitude.sv
// Magnitude unit: L1 sum or pipelined floor square root, clamped to 8 bits.
module sem_magnitude import sem_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       use_euclid,
   input  logic [9:0] ax,
   input  logic [9:0] ay,
   input  meta_type   meta_in,
   output logic [7:0] mag,
   output meta_type   meta_out
);

   localparam int STEPS = 8;

   logic [19:0] sqx_ff;
   logic [19:0] sqy_ff;
   logic [10:0] l1_sum_ff;
   meta_type    meta4_ff;
   logic [20:0] sq_sum;

   logic [15:0] rad_ff  [STEPS+1];
   logic [8:0]  rem_ff  [STEPS+1];
   logic [7:0]  root_ff [STEPS+1];
   logic        sat_ff  [STEPS+1];
   logic [7:0]  l1_ff   [STEPS+1];
   meta_type    meta_ff [STEPS+1];

   // Square both gradients and form the L1 sum
   always_ff @(posedge clock) begin
      if (reset) begin
         meta4_ff <= '0;
      end else if (adv) begin
         meta4_ff <= meta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff    <= 20'(ax) * 20'(ax);
         sqy_ff    <= 20'(ay) * 20'(ay);
         l1_sum_ff <= {1'b0, ax} + {1'b0, ay};
      end
   end

   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   // Add squares; a sum of 65536 or more saturates the root
   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff[0] <= '0;
      end else if (adv) begin
         meta_ff[0] <= meta4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff[0]  <= sq_sum[15:0];
         sat_ff[0]  <= |sq_sum[20:16];
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         l1_ff[0]   <= (l1_sum_ff > 11'(MAG_MAX)) ? MAG_MAX : l1_sum_ff[7:0];
      end
   end

   // One root bit per stage, radicand taken two bits at a time
   for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
      logic [10:0] rem_sh;
      logic [10:0] trial;
      logic [10:0] diff;
      logic        fit;

      always_comb begin
         rem_sh = {rem_ff[k], rad_ff[k][15:14]};
         trial  = {1'b0, root_ff[k], 2'b01};
         fit    = rem_sh >= trial;
         diff   = rem_sh - trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            meta_ff[k+1] <= '0;
         end else if (adv) begin
            meta_ff[k+1] <= meta_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k+1]  <= {rad_ff[k][13:0], 2'b00};
            rem_ff[k+1]  <= fit ? diff[8:0] : rem_sh[8:0];
            root_ff[k+1] <= {root_ff[k][6:0], fit};
            sat_ff[k+1]  <= sat_ff[k];
            l1_ff[k+1]   <= l1_ff[k];
         end
      end
   end

   // Select the magnitude; border centres give zero
   always_comb begin
      if (meta_ff[STEPS].zero) begin
         mag = '0;
      end else if (use_euclid) begin
         mag = sat_ff[STEPS] ? MAG_MAX : root_ff[STEPS];
      end else begin
         mag = l1_ff[STEPS];
      end
   end

   assign meta_out = meta_ff[STEPS];

endmodule
